// ===== hw/rtl/tkim_pkg.sv =====
// Package for the touch key I2C master: sequence steps, operation codes, key table.
// No dependencies.
`default_nettype none
package tkim_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_DEV_ADDR  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SETUP_REG = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_REG   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_TICKS     = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE     = 4'd0,
    S_W_START  = 4'd1,
    S_W_ADDR   = 4'd2,
    S_W_REG    = 4'd3,
    S_W_DATA   = 4'd4,
    S_W_STOP   = 4'd5,
    S_R_START  = 4'd6,
    S_R_ADDR   = 4'd7,
    S_R_REG    = 4'd8,
    S_R_RSTART = 4'd9,
    S_R_ADDRR  = 4'd10,
    S_R_LOW    = 4'd11,
    S_R_HIGH   = 4'd12,
    S_R_STOP   = 4'd13
  } step_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ADDR_NAK = 2'd1,
    ST_REG_NAK  = 2'd2,
    ST_LATE_NAK = 2'd3
  } status_e;

  // Classified request passed from front to back
  typedef struct packed {
    op_e        op;
    logic [4:0] table_index;
    logic [7:0] table_byte;
    logic       sda_level;
    logic       scl_level;
    logic       irq_level;
  } req_t;

  // Result item
  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic       key_valid;
    logic [7:0] key_code;
  } res_t;

  // One-hot mask to key character
  function automatic logic [8:0] key_decode(input logic [15:0] mask);
    logic [8:0] r;
    r = {1'b0, 8'hFF};
    case (mask)
      16'h0001: r = {1'b1, 8'h31};
      16'h0400: r = {1'b1, 8'h32};
      16'h0080: r = {1'b1, 8'h33};
      16'h0002: r = {1'b1, 8'h34};
      16'h0800: r = {1'b1, 8'h35};
      16'h0040: r = {1'b1, 8'h36};
      16'h0008: r = {1'b1, 8'h37};
      16'h0100: r = {1'b1, 8'h38};
      16'h0020: r = {1'b1, 8'h39};
      16'h0004: r = {1'b1, 8'h2A};
      16'h0200: r = {1'b1, 8'h30};
      16'h0010: r = {1'b1, 8'h23};
      default:  r = {1'b0, 8'hFF};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/touch_key_i2c_master_unit.sv =====
// Touch key I2C master top level: configuration registers, front queue, sequencer.
// An accepted request passes through the front queue and the sequencer into the output register.
// Throughput: one request per cycle while the result output is not stalled; the sequencer takes one step per request.
// Each request gives exactly one result; the two-entry queue absorbs output stalls.
// Reset (rst_ni low, asynchronous) empties the queue, idles the bus and loads
// the register defaults; setup table contents stay undefined until loaded.
`default_nettype none
module touch_key_i2c_master_unit
  import tkim_pkg::*;
#(
  parameter int unsigned TableBytes = 21
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // operation[1:0]
  input  wire logic [1:0]  s_tuser,
  // table_index[4:0], table_byte[12:5], sda_level[13], scl_level[14], irq_level[15]
  input  wire logic [15:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // scl_release[0], sda_release[1], busy_res[2], done_res[3], status[5:4],
  // key_valid[6], key_code[14:7], zero fill
  output logic [15:0]      m_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [6:0]  dev_addr_q;
  logic [7:0]  setup_reg_q, key_reg_q;
  logic [15:0] ticks_q;
  logic        req_valid, req_ready, res_valid;
  req_t        req;
  res_t        res;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= 7'd80;
      setup_reg_q <= 8'hB0;
      key_reg_q   <= 8'h08;
      ticks_q     <= 16'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DEV_ADDR:  dev_addr_q  <= cfg_data_i[6:0];
        CFG_SETUP_REG: setup_reg_q <= cfg_data_i[7:0];
        CFG_KEY_REG:   key_reg_q   <= cfg_data_i[7:0];
        CFG_TICKS:     ticks_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tkim_front u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tuser_i   (s_tuser),
    .s_tdata_i   (s_tdata),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  tkim_seq #(.TableBytes(TableBytes)) u_seq (
    .clk_i, .rst_ni,
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .dev_addr_i  (dev_addr_q),
    .setup_reg_i (setup_reg_q),
    .key_reg_i   (key_reg_q),
    .ticks_i     (ticks_q),
    .res_valid_o (res_valid),
    .res_ready_i (m_tready),
    .res_o       (res)
  );

  assign m_tvalid = res_valid;
  assign m_tdata  = {1'b0, res.key_code, res.key_valid, res.status, res.done_res,
                     res.busy_res, res.sda_release, res.scl_release};

endmodule
`default_nettype wire

// ===== hw/rtl/tkim_front.sv =====
// Front end: takes input requests, unpacks and classifies them into a short queue.
// Depends on tkim_pkg.
`default_nettype none
module tkim_front
  import tkim_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [1:0]  s_tuser_i,
  input  wire logic [15:0] s_tdata_i,
  output logic             req_valid_o,
  input  wire logic        req_ready_i,
  output req_t             req_o
);

  localparam int unsigned Depth = 2;

  req_t       fifo_q [Depth];
  logic [0:0] wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  req_t       req_in;

  // Unpack: operation from tuser; index, byte, sda, scl, irq from the lowest bit up
  always_comb begin
    req_in.op          = op_e'(s_tuser_i);
    req_in.table_index = s_tdata_i[4:0];
    req_in.table_byte  = s_tdata_i[12:5];
    req_in.sda_level   = s_tdata_i[13];
    req_in.scl_level   = s_tdata_i[14];
    req_in.irq_level   = s_tdata_i[15];
  end

  assign s_tready_o  = (cnt_q != 2'(Depth));
  assign push        = s_tvalid_i && s_tready_o;
  assign req_valid_o = (cnt_q != 2'd0);
  assign pop         = req_valid_o && req_ready_i;
  assign req_o       = fifo_q[rd_ptr_q];

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= req_in;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tkim_seq.sv =====
// Back end: the bus sequencer, setup table and result register.
// Depends on tkim_pkg.
`default_nettype none
module tkim_seq
  import tkim_pkg::*;
#(
  parameter int unsigned TableBytes = 21
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_valid_i,
  output logic             req_ready_o,
  input  req_t             req_i,
  input  wire logic [6:0]  dev_addr_i,
  input  wire logic [7:0]  setup_reg_i,
  input  wire logic [7:0]  key_reg_i,
  input  wire logic [15:0] ticks_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output res_t             res_o
);

  localparam int unsigned IdxW = (TableBytes > 1) ? $clog2(TableBytes) : 1;
  localparam int unsigned CntW = $clog2(TableBytes + 1);

  step_e            step_q, step_d;
  logic [15:0]      timer_q, timer_d;
  logic [3:0]       bit_q, bit_d;
  logic [CntW-1:0]  byte_q, byte_d;
  logic [7:0]       shift_q, shift_d;
  logic [7:0]       sum_q, sum_d;
  logic [15:0]      mask_q, mask_d;
  logic             armed_q, armed_d;
  logic [1:0]       half_q, half_d;
  logic             hold_q, hold_d;
  status_e          pend_q, pend_d;
  logic [7:0]       table_q [TableBytes];
  logic             res_full_q;
  res_t             res_q, res_n;
  logic             take;
  logic [7:0]       tbl_rd;
  logic [15:0]      lim;
  logic [8:0]       dec;

  assign req_ready_o = !res_full_q || res_ready_i;
  assign take        = req_valid_i && req_ready_o;
  assign res_valid_o = res_full_q;
  assign res_o       = res_q;
  assign lim         = (ticks_i == 16'd0) ? 16'd1 : ticks_i;
  assign dec         = key_decode(mask_q);
  assign tbl_rd      = (byte_q < CntW'(TableBytes)) ? table_q[byte_q[IdxW-1:0]] : 8'd0;

  // Setup table
  always_ff @(posedge clk_i) begin
    if (take && req_i.op == OP_LOAD && {1'b0, req_i.table_index} < 6'(TableBytes)) begin
      table_q[req_i.table_index[IdxW-1:0]] <= req_i.table_byte;
    end
  end

  function automatic step_e next_of(input step_e s, input logic more);
    case (s)
      S_W_START:  return S_W_ADDR;
      S_W_ADDR:   return S_W_REG;
      S_W_REG:    return S_W_DATA;
      S_W_DATA:   return more ? S_W_DATA : S_W_STOP;
      S_R_START:  return S_R_ADDR;
      S_R_ADDR:   return S_R_REG;
      S_R_REG:    return S_R_RSTART;
      S_R_RSTART: return S_R_ADDRR;
      S_R_ADDRR:  return S_R_LOW;
      S_R_LOW:    return S_R_HIGH;
      S_R_HIGH:   return S_R_STOP;
      default:    return S_IDLE;
    endcase
  endfunction

  // Sequencer next state and result
  always_comb begin
    step_e s;
    step_e nx;
    logic  enter;
    logic  is_start, is_stop, is_recv, more;
    logic  [7:0] dbyte;
    step_d  = step_q;  timer_d = timer_q; bit_d  = bit_q;  byte_d = byte_q;
    shift_d = shift_q; sum_d   = sum_q;   mask_d = mask_q; armed_d = armed_q;
    half_d  = half_q;  hold_d  = hold_q;  pend_d = pend_q;
    enter = 1'b0; nx = S_IDLE;
    res_n = '0;
    res_n.key_code = 8'hFF;
    s        = step_q;
    is_start = (s == S_W_START) || (s == S_R_START) || (s == S_R_RSTART);
    is_stop  = (s == S_W_STOP) || (s == S_R_STOP);
    is_recv  = (s == S_R_LOW) || (s == S_R_HIGH);
    more     = (byte_q < CntW'(TableBytes));

    case (req_i.op)
      OP_WRITE: begin
        if (s == S_IDLE) begin
          byte_d = '0; sum_d = '0; pend_d = ST_OK;
          enter = 1'b1; nx = S_W_START;
        end
      end
      OP_TICK: begin
        if (s == S_IDLE) begin
          if (!req_i.irq_level && armed_q) begin
            pend_d = ST_OK; enter = 1'b1; nx = S_R_START;
          end
        end else if (hold_q) begin
          if (req_i.scl_level) begin
            enter = 1'b1; nx = next_of(s, more);
          end
        end else if (timer_q + 16'd1 >= lim) begin
          timer_d = '0;
          if (is_start) begin
            half_d = half_q + 2'd1;
            if (half_q == 2'd2) begin enter = 1'b1; nx = next_of(s, more); end
          end else if (is_stop) begin
            half_d = half_q + 2'd1;
            if (half_q == 2'd2) begin
              res_n.done_res = 1'b1;
              res_n.status   = pend_q;
              if (s == S_R_STOP && pend_q == ST_OK && dec[8]) begin
                res_n.key_valid = 1'b1;
                res_n.key_code  = dec[7:0];
                armed_d = 1'b0;
              end
              enter = 1'b1; nx = S_IDLE;
            end
          end else if (half_q == 2'd0) begin
            half_d = 2'd1;
          end else if (bit_q < 4'd8) begin
            if (is_recv) shift_d = {shift_q[6:0], req_i.sda_level};
            bit_d  = bit_q + 4'd1;
            half_d = 2'd0;
            if (is_recv && bit_q == 4'd7) begin
              if (s == S_R_LOW) mask_d = {mask_q[15:8], shift_q[6:0], req_i.sda_level};
              else mask_d = {shift_q[6:0], req_i.sda_level, mask_q[7:0]};
            end
          end else if (is_recv) begin
            enter = 1'b1; nx = next_of(s, more);
          end else if (req_i.sda_level) begin
            if (s == S_W_ADDR || s == S_R_ADDR) pend_d = ST_ADDR_NAK;
            else if (s == S_W_REG || s == S_R_REG) pend_d = ST_REG_NAK;
            else pend_d = ST_LATE_NAK;
            enter = 1'b1;
            nx = (s <= S_W_STOP) ? S_W_STOP : S_R_STOP;
          end else if (req_i.scl_level) begin
            enter = 1'b1; nx = next_of(s, more);
          end else begin
            hold_d = 1'b1;
          end
        end else begin
          timer_d = timer_q + 16'd1;
        end
        if (req_i.irq_level) armed_d = 1'b1;
      end
      default: ;
    endcase

    // Data-byte advance counts the byte just finished
    if (enter && s == S_W_DATA && nx == S_W_DATA) byte_d = byte_q + 1'b1;

    // Entry into a step
    if (enter) begin
      step_d = nx; half_d = '0; bit_d = '0; timer_d = '0; hold_d = 1'b0;
      dbyte = (byte_d < CntW'(TableBytes)) ?
              table_q[byte_d[IdxW-1:0]] : sum_q;
      case (nx)
        S_W_ADDR, S_R_ADDR: shift_d = {dev_addr_i, 1'b0};
        S_R_ADDRR:          shift_d = {dev_addr_i, 1'b1};
        S_W_REG:            shift_d = setup_reg_i;
        S_R_REG:            shift_d = key_reg_i;
        S_W_DATA: begin
          shift_d = dbyte;
          if (byte_d < CntW'(TableBytes)) sum_d = sum_q + dbyte;
        end
        default:            shift_d = '0;
      endcase
    end else begin
      dbyte = tbl_rd;
    end

    // Line drive after this request
    res_n.busy_res = (step_d != S_IDLE);
    if (step_d == S_IDLE) begin
      res_n.scl_release = 1'b1; res_n.sda_release = 1'b1;
    end else if (step_d == S_W_START || step_d == S_R_START || step_d == S_R_RSTART) begin
      res_n.scl_release = (half_d != 2'd0); res_n.sda_release = (half_d != 2'd2);
    end else if (step_d == S_W_STOP || step_d == S_R_STOP) begin
      res_n.scl_release = (half_d != 2'd0); res_n.sda_release = (half_d == 2'd2);
    end else begin
      res_n.scl_release = half_d[0];
      if (bit_d < 4'd8)
        res_n.sda_release = (step_d == S_R_LOW || step_d == S_R_HIGH) ? 1'b1 :
                            shift_d[3'd7 - bit_d[2:0]];
      else if (step_d == S_R_LOW)
        res_n.sda_release = 1'b0;
      else
        res_n.sda_release = 1'b1;
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE; timer_q <= '0; bit_q <= '0; byte_q <= '0;
      shift_q <= '0; sum_q <= '0; mask_q <= '0; armed_q <= 1'b1;
      half_q <= '0; hold_q <= 1'b0; pend_q <= ST_OK;
    end else if (take) begin
      step_q <= step_d; timer_q <= timer_d; bit_q <= bit_d; byte_q <= byte_d;
      shift_q <= shift_d; sum_q <= sum_d; mask_q <= mask_d; armed_q <= armed_d;
      half_q <= half_d; hold_q <= hold_d; pend_q <= pend_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_full_q <= 1'b0;
    end else if (take) begin
      res_full_q <= 1'b1;
    end else if (res_ready_i) begin
      res_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_n;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tkim_checker.sv =====
// Port-level checker for the touch key I2C master, bound to the top level.
// Does not import tkim_pkg; it sees only the bound top level's ports.
`default_nettype none
module tkim_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Status is zero unless a transaction ends
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tdata[3] |-> m_tdata[5:4] == 2'd0)
    else $error("status without done");

  // A key only comes with a good finish
  a_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[6] |-> m_tdata[3] && m_tdata[5:4] == 2'd0 && !m_tdata[2])
    else $error("key without clean finish");

  // Idle bus releases both lines
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tdata[2] |-> m_tdata[0] && m_tdata[1])
    else $error("idle bus not released");

endmodule

bind touch_key_i2c_master_unit tkim_checker u_tkim_checker (
  .clk_i, .rst_ni, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire
